// ===== sv/ubx_frame_deframer_core_macros.svh =====
// Assertion macros used by the checker file of the frame deframer.
// Each macro expects a signal named clk, and UBXD_ASSERT also arst_n, where it is used.
`ifndef UBX_FRAME_DEFRAMER_CORE_MACROS_SVH
`define UBX_FRAME_DEFRAMER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define UBXD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, for a property that must also hold during reset.
`define UBXD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ubxd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubxd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ubxd_pkg;

	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_GOOD     = 2'd1;
	localparam logic [1:0] KIND_CK_BAD   = 2'd2;
	localparam logic [1:0] KIND_TOO_LONG = 2'd3;

	localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

	localparam logic [7:0]  RST_SYNC_FIRST  = 8'hB5;
	localparam logic [7:0]  RST_SYNC_SECOND = 8'h62;
	localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1024;

	// Header bytes: class, id, length low, length high.
	localparam logic [15:0] HDR_BYTES = 16'd4;

	typedef struct packed {
		logic [7:0]  sync_first;
		logic [7:0]  sync_second;
		logic [15:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  msg_class;
		logic [7:0]  msg_id;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic        last_byte;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/ubxd_parser.sv =====
// ----------------------------------------------------------------------------
// ubxd_parser
// Frame state machine and checksum; one received byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	input  wire ubxd_pkg::cfg_t   cfg,
	output logic                  res_valid,
	output ubxd_pkg::result_t     res
);

	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_HEADER  = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_CK_A    = 3'd4,
		PH_CK_B    = 3'd5
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [15:0] len_q, len_d;
	logic [7:0]  class_q, class_d;
	logic [7:0]  id_q, id_d;
	logic [7:0]  sum_a_q, sum_a_d;
	logic [7:0]  sum_b_q, sum_b_d;
	logic [7:0]  ck_a_q, ck_a_d;
	logic [7:0]  sum_a_add;
	logic [15:0] count_inc;
	logic        is_last;

	assign sum_a_add = sum_a_q + rx_byte;
	assign count_inc = count_q + 16'd1;
	// The payload phase is only entered with a nonzero length.
	assign is_last   = ({1'b0, count_q} + 17'd1) >= {1'b0, len_q};

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		len_d     = len_q;
		class_d   = class_q;
		id_d      = id_q;
		sum_a_d   = sum_a_q;
		sum_b_d   = sum_b_q;
		ck_a_d    = ck_a_q;
		res_valid = 1'b0;
		res.kind  = ubxd_pkg::KIND_PAYLOAD;
		res.data_byte  = 8'd0;
		res.byte_index = 16'd0;
		res.last_byte  = 1'b0;
		case (phase_q)
			PH_SYNC2: begin
				if (rx_byte == cfg.sync_second) begin
					count_d = 16'd0;
					sum_a_d = 8'd0;
					sum_b_d = 8'd0;
					phase_d = PH_HEADER;
				end else begin
					phase_d = PH_SYNC1;
				end
			end
			PH_HEADER: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_q + sum_a_add;
				case (count_q)
					16'd0:   class_d = rx_byte;
					16'd1:   id_d = rx_byte;
					16'd2:   len_d = {8'd0, rx_byte};
					default: len_d = {rx_byte, len_q[7:0]};
				endcase
				count_d = count_inc;
				if (count_inc >= ubxd_pkg::HDR_BYTES) begin
					count_d = 16'd0;
					if (len_d > cfg.max_payload) begin
						phase_d   = PH_SYNC1;
						res_valid = 1'b1;
						res.kind  = ubxd_pkg::KIND_TOO_LONG;
					end else if (len_d == 16'd0) begin
						phase_d = PH_CK_A;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				sum_a_d        = sum_a_add;
				sum_b_d        = sum_b_q + sum_a_add;
				res_valid      = 1'b1;
				res.kind       = ubxd_pkg::KIND_PAYLOAD;
				res.data_byte  = rx_byte;
				res.byte_index = count_q;
				res.last_byte  = is_last;
				if (is_last) begin
					phase_d = PH_CK_A;
					count_d = 16'd0;
				end else begin
					count_d = count_inc;
				end
			end
			PH_CK_A: begin
				ck_a_d  = rx_byte;
				phase_d = PH_CK_B;
			end
			PH_CK_B: begin
				phase_d   = PH_SYNC1;
				res_valid = 1'b1;
				res.kind  = ((ck_a_q == sum_a_q) && (rx_byte == sum_b_q)) ?
					ubxd_pkg::KIND_GOOD : ubxd_pkg::KIND_CK_BAD;
			end
			default: begin
				phase_d = (rx_byte == cfg.sync_first) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
		res.msg_class    = class_d;
		res.msg_id       = id_d;
		res.frame_length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			count_q <= 16'd0;
			len_q   <= 16'd0;
			class_q <= 8'd0;
			id_q    <= 8'd0;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
			ck_a_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			len_q   <= len_d;
			class_q <= class_d;
			id_q    <= id_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			ck_a_q  <= ck_a_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/ubxd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ubxd_out_reg
// Result register driving the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ubxd_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire logic                res_valid,
	input  wire ubxd_pkg::result_t   res,
	output logic                     can_load,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [55:0]              m_axis_tdata,
	output logic [1:0]               m_axis_tuser,
	output logic                     m_axis_tlast
);

	logic              valid_q;
	ubxd_pkg::result_t res_q;

	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res_valid;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res_valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.frame_length, res_q.byte_index, res_q.data_byte,
		res_q.msg_id, res_q.msg_class};
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tlast  = res_q.last_byte;

endmodule

`default_nettype wire

// ===== sv/ubx_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// ubx_frame_deframer_core
// Finds sync bytes, parses a frame header, streams payload bytes out and
// checks the 8-bit Fletcher checksum at the frame end.
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata: class, id, data byte, index, length; tuser kind; tlast
// cfg       in   cfg_index selects a register, cfg_data carries its value
//
// One byte is taken per cycle when the output side keeps up; a byte waits in
// the input register until the result register can take its result, and
// that result is then loaded there and offered on the output stream.
// Reset is asynchronous and leaves the parser hunting the first sync byte
// with default registers.
// A stalled output holds the parser and, one byte later, the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ubx_frame_deframer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,   // [7:0] msg_class, [15:8] msg_id,
	                                         // [23:16] data_byte,
	                                         // [39:24] byte_index,
	                                         // [55:40] frame_length
	output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
	output logic             m_axis_tlast,   // last_byte
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	ubxd_pkg::cfg_t    cfg_q;
	ubxd_pkg::result_t res;
	logic              res_valid;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              can_load;
	logic              advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= ubxd_pkg::RST_SYNC_FIRST;
			cfg_q.sync_second <= ubxd_pkg::RST_SYNC_SECOND;
			cfg_q.max_payload <= ubxd_pkg::RST_MAX_PAYLOAD;
		end else if (cfg_valid) begin
			case (cfg_index)
				ubxd_pkg::REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data[7:0];
				ubxd_pkg::REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data[7:0];
				ubxd_pkg::REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register empties whenever the parser can place its result.
	assign advance       = valid_s1 && can_load;
	assign s_axis_tready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ubxd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	ubxd_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.res_valid     (res_valid),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/ubxd_checker.sv =====
// ----------------------------------------------------------------------------
// ubxd_props
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ubx_frame_deframer_core_macros.svh"

module ubxd_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic        out_stall;
	logic        out_end;
	logic        out_last;
	logic        payload_clear;
	logic [58:0] out_word;
	logic [16:0] last_count;
	logic [16:0] frame_len;

	assign out_stall     = m_axis_tvalid && !m_axis_tready;
	assign out_end       = m_axis_tvalid && (m_axis_tuser != ubxd_pkg::KIND_PAYLOAD);
	assign out_last      = m_axis_tvalid && m_axis_tlast;
	assign payload_clear = (m_axis_tdata[39:16] == 24'd0) && !m_axis_tlast;
	assign out_word      = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
	assign last_count    = {1'b0, m_axis_tdata[39:24]} + 17'd1;
	assign frame_len     = {1'b0, m_axis_tdata[55:40]};

	`UBXD_ASSERT(a_out_hold, out_stall |=> (m_axis_tvalid && $stable(out_word)), "stalled request changed")
	`UBXD_ASSERT(a_end_fields, out_end |-> payload_clear, "frame-end request carries payload fields")
	`UBXD_ASSERT(a_last_index, out_last |-> (last_count == frame_len), "last index and length disagree")
	`UBXD_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind ubx_frame_deframer_core ubxd_props u_checker (.*);

`default_nettype wire

// ===== bench/ubxd_checker.sv =====
// ----------------------------------------------------------------------------
// ubxd_checker
// Watches the byte, result and register channels of the frame deframer. It
// keeps its own copy of the parser state, works out the results that each
// accepted byte must give, and compares every delivered result with them.
// ----------------------------------------------------------------------------
module ubxd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          payload_seen,
	output int          good_seen,
	output int          bad_ck_seen,
	output int          too_long_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import ubxd_pkg::*;

	typedef enum logic [2:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		IN_HEADER,
		IN_PAYLOAD,
		AT_CK_A,
		AT_CK_B
	} parse_phase_e;

	cfg_t         regs;
	parse_phase_e phase;
	logic [15:0]  count;
	logic [15:0]  frame_len;
	logic [7:0]   cls;
	logic [7:0]   id;
	logic [7:0]   sum_a;
	logic [7:0]   sum_b;
	logic [7:0]   ck_a_rx;
	result_t      frame_results[$];
	int           fail_tally;
	int           payload_tally;
	int           good_tally;
	int           bad_ck_tally;
	int           too_long_tally;

	task automatic report_mismatch(input string msg);
		fail_tally++;
		// Keep the log readable if the block goes badly wrong.
		if (fail_tally <= 100)
			$display("[%0t] deframer mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
	                           input logic [15:0] got);
		if (want !== got)
			report_mismatch($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	function automatic result_t make_result(input logic [1:0] kind,
	                                        input logic [7:0] data,
	                                        input logic [15:0] idx,
	                                        input logic is_last);
		result_t r;
		r.kind         = kind;
		r.msg_class    = cls;
		r.msg_id       = id;
		r.data_byte    = data;
		r.byte_index   = idx;
		r.frame_length = frame_len;
		r.last_byte    = is_last;
		return r;
	endfunction

	task automatic add_to_sum(input logic [7:0] b);
		sum_a = sum_a + b;
		sum_b = sum_b + sum_a;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		logic is_last;
		case (phase)
			HUNT_SECOND: begin
				// A wrong second sync byte is dropped, not retried as a first one.
				if (b == regs.sync_second) begin
					count = '0;
					sum_a = '0;
					sum_b = '0;
					phase = IN_HEADER;
				end else begin
					phase = HUNT_FIRST;
				end
			end
			IN_HEADER: begin
				add_to_sum(b);
				case (count)
					16'd0: cls = b;
					16'd1: id = b;
					16'd2: frame_len = {8'h00, b};
					default: frame_len[15:8] = b;
				endcase
				count = count + 16'd1;
				if (count >= HDR_BYTES) begin
					count = '0;
					if (frame_len > regs.max_payload) begin
						phase = HUNT_FIRST;
						frame_results.push_back(make_result(KIND_TOO_LONG, '0, '0, 1'b0));
					end else if (frame_len == 16'd0) begin
						phase = AT_CK_A;
					end else begin
						phase = IN_PAYLOAD;
					end
				end
			end
			IN_PAYLOAD: begin
				is_last = ({16'd0, count} + 32'd1 >= {16'd0, frame_len});
				add_to_sum(b);
				frame_results.push_back(make_result(KIND_PAYLOAD, b, count, is_last));
				if (is_last) begin
					phase = AT_CK_A;
					count = '0;
				end else begin
					count = count + 16'd1;
				end
			end
			AT_CK_A: begin
				ck_a_rx = b;
				phase = AT_CK_B;
			end
			AT_CK_B: begin
				phase = HUNT_FIRST;
				if (ck_a_rx == sum_a && b == sum_b)
					frame_results.push_back(make_result(KIND_GOOD, '0, '0, 1'b0));
				else
					frame_results.push_back(make_result(KIND_CK_BAD, '0, '0, 1'b0));
			end
			default: begin
				phase = (b == regs.sync_first) ? HUNT_SECOND : HUNT_FIRST;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			regs.sync_first  = RST_SYNC_FIRST;
			regs.sync_second = RST_SYNC_SECOND;
			regs.max_payload = RST_MAX_PAYLOAD;
			phase            = HUNT_FIRST;
			count            = '0;
			frame_len        = '0;
			cls              = '0;
			id               = '0;
			sum_a            = '0;
			sum_b            = '0;
			ck_a_rx          = '0;
			frame_results.delete();
			fail_tally       = 0;
			payload_tally    = 0;
			good_tally       = 0;
			bad_ck_tally     = 0;
			too_long_tally   = 0;
		end else begin
			// Results trail their byte through the input and result registers, so check first.
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_results.size() == 0) begin
					report_mismatch($sformatf("result kind %0d arrived with none expected",
					                          m_axis_tuser));
				end else begin
					want = frame_results.pop_front();
					check_field("result_kind", want.kind, m_axis_tuser);
					check_field("msg_class", want.msg_class, m_axis_tdata[7:0]);
					check_field("msg_id", want.msg_id, m_axis_tdata[15:8]);
					check_field("data_byte", want.data_byte, m_axis_tdata[23:16]);
					check_field("byte_index", want.byte_index, m_axis_tdata[39:24]);
					check_field("frame_length", want.frame_length, m_axis_tdata[55:40]);
					check_field("last_byte", want.last_byte, m_axis_tlast);
				end
				case (m_axis_tuser)
					KIND_PAYLOAD: payload_tally++;
					KIND_GOOD:    good_tally++;
					KIND_CK_BAD:  bad_ck_tally++;
					default:      too_long_tally++;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SYNC_FIRST:  regs.sync_first  = cfg_data[7:0];
					REG_SYNC_SECOND: regs.sync_second = cfg_data[7:0];
					REG_MAX_PAYLOAD: regs.max_payload = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				deframe_byte(s_axis_tdata);
		end
		mismatches    <= fail_tally;
		outstanding   <= frame_results.size();
		payload_seen  <= payload_tally;
		good_seen     <= good_tally;
		bad_ck_seen   <= bad_ck_tally;
		too_long_seen <= too_long_tally;
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Byte stream stimulus for the frame deframer. Sends short directed frames,
// then mostly well-formed random frames mixed with bad checksums, oversize
// headers, broken sync pairs and noise, under several register settings,
// while both stream sides idle at random. The checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         CYCLE_LIMIT = 400000;
	localparam logic [1:0] REG_SPARE   = 2'd3;

	typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_HOLD} sink_mode_e;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;

	int             fail_count;
	int             outstanding;
	int             payload_seen;
	int             good_seen;
	int             bad_ck_seen;
	int             too_long_seen;
	int             bytes_sent    = 0;
	int             settings_used = 1;
	int             burst_left    = 0;
	ubxd_pkg::cfg_t active;

	ubx_frame_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ubxd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (fail_count),
		.outstanding   (outstanding),
		.payload_seen  (payload_seen),
		.good_seen     (good_seen),
		.bad_ck_seen   (bad_ck_seen),
		.too_long_seen (too_long_seen)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
		         cycles, outstanding);
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: open, choppy and held-off stretches. The fourth stretch is
	// always a long hold-off so the block backs up into its input at least once.
	initial begin : sink
		sink_mode_e mode;
		int         seg;
		int         len;
		int         stall_pct;
		seg = 0;
		forever begin
			if (seg == 3 || $urandom_range(0, 11) == 0)
				mode = SINK_HOLD;
			else if ($urandom_range(0, 1) == 0)
				mode = SINK_OPEN;
			else
				mode = SINK_CHOPPY;
			len = (mode == SINK_HOLD) ? $urandom_range(150, 300) : $urandom_range(10, 80);
			stall_pct = $urandom_range(10, 60);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					SINK_OPEN:   m_axis_tready <= 1'b1;
					SINK_CHOPPY: m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
					default:     m_axis_tready <= 1'b0;
				endcase
			end
			seg++;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
	                          input logic [15:0] len, input bit corrupt);
		logic [7:0] body[$];
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		logic [7:0] flip;
		body.push_back(cls);
		body.push_back(id);
		body.push_back(len[7:0]);
		body.push_back(len[15:8]);
		repeat (len) body.push_back(8'($urandom_range(0, 255)));
		ck_a = '0;
		ck_b = '0;
		foreach (body[i]) begin
			ck_a = ck_a + body[i];
			ck_b = ck_b + ck_a;
		end
		flip = 8'($urandom_range(1, 255));
		if (corrupt) begin
			if ($urandom_range(0, 1) == 0)
				ck_a = ck_a ^ flip;
			else
				ck_b = ck_b ^ flip;
		end
		send_byte(active.sync_first);
		send_byte(active.sync_second);
		foreach (body[i]) send_byte(body[i]);
		send_byte(ck_a);
		send_byte(ck_b);
	endtask

	// Header whose length exceeds the limit; the block reports it and resyncs.
	task automatic send_oversize(input logic [15:0] len);
		send_byte(active.sync_first);
		send_byte(active.sync_second);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
		send_byte(len[7:0]);
		send_byte(len[15:8]);
	endtask

	function automatic logic [15:0] pick_length(input logic [15:0] limit);
		logic [15:0] cap;
		cap = (limit < 16'd16) ? limit : 16'd16;
		if ($urandom_range(0, 9) == 0)
			return (limit <= 16'd64) ? limit : 16'($urandom_range(17, 64));
		return 16'($urandom_range(0, cap));
	endfunction

	task automatic random_traffic(input int budget);
		int          start;
		int          pick;
		int          lo;
		logic [7:0]  b;
		logic [15:0] len;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 88 && pick >= 80 && active.max_payload != 16'hFFFF) begin
				lo = active.max_payload + 1;
				len = ($urandom_range(0, 1) == 0) ? 16'(lo) : 16'($urandom_range(lo, 65535));
				send_oversize(len);
			end else if (pick < 88) begin
				send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				           pick_length(active.max_payload), pick >= 70 && pick < 80);
			end else if (pick < 94) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
			end else begin
				// Broken sync pair: often the first sync byte repeated.
				send_byte(active.sync_first);
				b = ($urandom_range(0, 1) == 0) ? active.sync_first
				                                : 8'($urandom_range(0, 255));
				if (b == active.sync_second)
					b = ~active.sync_second;
				send_byte(b);
			end
		end
	endtask

	task automatic write_one(input logic [1:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Sync registers keep only their low byte, so the upper byte is junk.
	task automatic program_regs(input ubxd_pkg::cfg_t c, input bit touch_spare);
		logic [7:0]  junk;
		logic [15:0] spare;
		junk  = 8'($urandom_range(0, 255));
		spare = 16'($urandom_range(0, 65535));
		write_one(ubxd_pkg::REG_SYNC_FIRST, {junk, c.sync_first});
		write_one(ubxd_pkg::REG_SYNC_SECOND, {~junk, c.sync_second});
		write_one(ubxd_pkg::REG_MAX_PAYLOAD, c.max_payload);
		if (touch_spare)
			write_one(REG_SPARE, spare);
		cfg_valid <= 1'b0;
		active = c;
		settings_used++;
	endtask

	// Let the block drain; the checker's count of expected results is registered.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		ubxd_pkg::cfg_t c;
		arst_n <= 1'b0;
		active.sync_first  = ubxd_pkg::RST_SYNC_FIRST;
		active.sync_second = ubxd_pkg::RST_SYNC_SECOND;
		active.max_payload = ubxd_pkg::RST_MAX_PAYLOAD;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Repeated first sync byte, then a stray second sync byte: no frame.
		send_byte(ubxd_pkg::RST_SYNC_FIRST);
		send_byte(ubxd_pkg::RST_SYNC_FIRST);
		send_byte(ubxd_pkg::RST_SYNC_SECOND);
		send_frame(8'h00, 8'hFF, 16'd0, 1'b0);
		send_frame(8'hFF, 8'h00, 16'd1, 1'b1);
		send_frame(8'h5A, 8'hA5, 16'd3, 1'b0);
		send_oversize(16'hFFFF);
		random_traffic(300);
		settle();

		c.sync_first  = 8'h00;
		c.sync_second = 8'hFF;
		c.max_payload = 16'h0000;
		program_regs(c, 1'b1);
		random_traffic(250);
		settle();

		c.sync_first  = 8'hFF;
		c.sync_second = 8'h00;
		c.max_payload = 16'hFFFF;
		program_regs(c, 1'b0);
		random_traffic(250);
		settle();

		c.sync_first  = 8'($urandom_range(0, 255));
		c.sync_second = 8'($urandom_range(0, 255));
		c.max_payload = 16'($urandom_range(0, 40));
		program_regs(c, 1'b1);
		random_traffic(200);
		settle();

		// Both sync bytes equal.
		c.sync_second = c.sync_first;
		c.max_payload = 16'($urandom_range(0, 40));
		program_regs(c, 1'b1);
		random_traffic(200);
		settle();

		c.sync_first  = ubxd_pkg::RST_SYNC_FIRST;
		c.sync_second = ubxd_pkg::RST_SYNC_SECOND;
		c.max_payload = ubxd_pkg::RST_MAX_PAYLOAD;
		program_regs(c, 1'b1);
		random_traffic(250);
		settle();

		$display("Sent %0d bytes under %0d register settings; checked %0d payload bytes,",
		         bytes_sent, settings_used, payload_seen);
		$display("%0d good frames, %0d bad checksums and %0d oversize headers.",
		         good_seen, bad_ck_seen, too_long_seen);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches found.", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
